// ===== design/sha256_pkg.sv =====
`default_nettype none
package sha256_pkg;

    typedef logic [31:0] t_word;

    localparam int unsigned ROUNDS = 64;
    localparam int unsigned WORDS  = 8;

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [5:0] PAD_FILL = 6'd56;

    localparam t_word K_TABLE [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam t_word H_INIT [WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic t_word rotr(input t_word x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic t_word big_sigma0(input t_word x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic t_word big_sigma1(input t_word x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic t_word small_sigma0(input t_word x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic t_word small_sigma1(input t_word x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage
`default_nettype wire

// ===== design/sha256_stream_hasher_unit.sv =====
`default_nettype none
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata: data_byte, tuser: has_data,
//                                             tlast: end_of_message
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: digest_word, tuser: word_index,
//                                             tlast: last_word
//
// A byte request is taken only while the unit is idle. The 64th byte of a block
// stalls the input: one shared round unit runs the 64 rounds, one per cycle, then
// the fold state adds the working variables into the chaining words.
// An end request pads the message with 9 to 72 bytes, runs one or two
// compressions, then gives 8 digest words, each held until taken.
// Reset (synchronous, active low) restores the initial hash values and length zero.
module sha256_stream_hasher_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic [0:0]  s_axis_tuser,   // [0] has_data
    input  wire logic        s_axis_tlast,   // end_of_message
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]       m_axis_tuser,   // [2:0] word_index
    output logic             m_axis_tlast    // last_word
);
    import sha256_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PAD   = 3'd1;
    localparam logic [2:0] ST_ROUND = 3'd2;
    localparam logic [2:0] ST_FOLD  = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    localparam logic [3:0] LEN_BYTES = 4'd8;

    logic [2:0]   r_state, n_state;
    logic [5:0]   r_fill, n_fill;
    logic [60:0]  r_len, n_len;
    logic [63:0]  r_bits;
    logic [3:0]   r_cnt;
    logic         r_sent80;
    logic         r_closing;
    logic [5:0]   r_rnd;
    logic [2:0]   r_oidx;
    logic [511:0] r_blk;
    t_word        r_h [WORDS];
    t_word        r_v [WORDS];

    logic  w_s_acc, w_m_acc, w_push, w_wrap, w_zero_pad;
    logic  [7:0] w_byte;
    t_word w_t1, w_t2, w_wnew, w_e, w_a;

    assign w_s_acc = s_axis_tvalid & s_axis_tready;
    assign w_m_acc = m_axis_tvalid & m_axis_tready;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = (r_state == ST_OUT);
    assign m_axis_tdata  = r_h[r_oidx];
    assign m_axis_tuser  = r_oidx;
    assign m_axis_tlast  = (r_oidx == 3'd7);

    assign w_zero_pad = (r_cnt == 4'd0) && (r_fill != PAD_FILL);
    assign w_wrap     = (r_fill == 6'd63);
    assign n_fill     = r_fill + 6'd1;
    assign n_len      = r_len + {60'd0, s_axis_tuser[0]};

    always_comb begin
        w_push = 1'b0;
        w_byte = s_axis_tdata;
        case (r_state)
            ST_IDLE: begin
                w_push = w_s_acc & s_axis_tuser[0];
            end
            ST_PAD: begin
                w_push = 1'b1;
                if (!r_sent80) begin
                    w_byte = PAD_MARK;
                end else if (w_zero_pad) begin
                    w_byte = 8'h00;
                end else begin
                    w_byte = r_bits[63:56];
                end
            end
            default: begin
                w_push = 1'b0;
            end
        endcase
    end

    // one SHA-256 round and one schedule word per cycle
    assign w_e    = r_v[4];
    assign w_a    = r_v[0];
    assign w_t1   = r_v[7] + big_sigma1(w_e) + ((w_e & r_v[5]) ^ (~w_e & r_v[6]))
                  + K_TABLE[r_rnd] + r_blk[511:480];
    assign w_t2   = big_sigma0(w_a) + ((w_a & r_v[1]) ^ (w_a & r_v[2]) ^ (r_v[1] & r_v[2]));
    assign w_wnew = r_blk[511:480] + small_sigma0(r_blk[479:448]) + r_blk[223:192]
                  + small_sigma1(r_blk[63:32]);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_s_acc) begin
                    if (w_push && w_wrap) begin
                        n_state = ST_ROUND;
                    end else if (s_axis_tlast) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                if (w_wrap) begin
                    n_state = ST_ROUND;
                end
            end
            ST_ROUND: begin
                if (r_rnd == 6'd63) begin
                    n_state = ST_FOLD;
                end
            end
            ST_FOLD: begin
                if (!r_closing) begin
                    n_state = ST_IDLE;
                end else if (r_cnt == LEN_BYTES) begin
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_PAD;
                end
            end
            ST_OUT: begin
                if (w_m_acc && m_axis_tlast) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control and chaining state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_fill    <= '0;
            r_len     <= '0;
            r_cnt     <= '0;
            r_sent80  <= 1'b0;
            r_closing <= 1'b0;
            r_rnd     <= '0;
            r_oidx    <= '0;
            for (int i = 0; i < WORDS; i++) begin
                r_h[i] <= H_INIT[i];
            end
        end else begin
            r_state <= n_state;
            if (w_push) begin
                r_fill <= n_fill;
            end
            if (r_state == ST_IDLE && w_s_acc) begin
                r_len <= n_len;
                if (s_axis_tlast) begin
                    r_closing <= 1'b1;
                end
            end
            if (r_state == ST_PAD) begin
                if (!r_sent80) begin
                    r_sent80 <= 1'b1;
                end else if (!w_zero_pad) begin
                    r_cnt <= r_cnt + 4'd1;
                end
            end
            if (r_state == ST_ROUND) begin
                r_rnd <= r_rnd + 6'd1;
            end
            if (r_state == ST_FOLD) begin
                for (int i = 0; i < WORDS; i++) begin
                    r_h[i] <= r_h[i] + r_v[i];
                end
            end
            if (w_m_acc) begin
                r_oidx <= r_oidx + 3'd1;
                if (m_axis_tlast) begin
                    // restart for the next message
                    r_fill    <= '0;
                    r_len     <= '0;
                    r_cnt     <= '0;
                    r_sent80  <= 1'b0;
                    r_closing <= 1'b0;
                    for (int i = 0; i < WORDS; i++) begin
                        r_h[i] <= H_INIT[i];
                    end
                end
            end
        end
    end

    // payload: block shift line, working variables, length bytes
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_blk <= {r_blk[503:0], w_byte};
            if (w_wrap) begin
                for (int i = 0; i < WORDS; i++) begin
                    r_v[i] <= r_h[i];
                end
            end
        end else if (r_state == ST_ROUND) begin
            r_blk <= {r_blk[479:0], w_wnew};
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + w_t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= w_t1 + w_t2;
        end
        if (r_state == ST_IDLE && w_s_acc && s_axis_tlast) begin
            r_bits <= {n_len, 3'b000};
        end else if (r_state == ST_PAD && r_sent80 && !w_zero_pad) begin
            r_bits <= {r_bits[55:0], 8'h00};
        end
    end

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    import sha256_pkg::*;

    localparam int HOLD_CYCLES    = 400;
    localparam int RANDOM_REQS    = 300;
    localparam int DRAIN_CYCLES   = 200;
    localparam int IDLE_PCT       = 14;
    localparam int EDGE_LENS [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};

    localparam logic [255:0] DIGEST_EMPTY =
        256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855;
    localparam logic [255:0] DIGEST_ABC =
        256'hba7816bf8f01cfea414140de5dae2223b00361a396177a9cb410ff61f20015ad;

    localparam logic [31:0] IV_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef struct packed {
        logic [7:0]   data_byte;
        logic         has_data;
        logic         end_of_msg;
        logic         use_known;
        logic [255:0] known;
    } t_dir_row;

    // known digests only where the message is a standard test vector
    localparam int DIR_ROWS = 13;
    localparam t_dir_row DIR_TABLE [DIR_ROWS] = '{
        '{8'h00, 1'b0, 1'b1, 1'b1, DIGEST_EMPTY},
        '{8'h61, 1'b1, 1'b0, 1'b0, 256'h0},
        '{8'h62, 1'b1, 1'b0, 1'b0, 256'h0},
        '{8'h63, 1'b1, 1'b1, 1'b1, DIGEST_ABC},
        '{8'hff, 1'b0, 1'b0, 1'b0, 256'h0},
        '{8'h00, 1'b1, 1'b0, 1'b0, 256'h0},
        '{8'hff, 1'b1, 1'b0, 1'b0, 256'h0},
        '{8'ha5, 1'b0, 1'b0, 1'b0, 256'h0},
        '{8'h3c, 1'b0, 1'b1, 1'b0, 256'h0},
        '{8'hff, 1'b1, 1'b1, 1'b0, 256'h0},
        '{8'h00, 1'b1, 1'b1, 1'b0, 256'h0},
        '{8'h80, 1'b0, 1'b0, 1'b0, 256'h0},
        '{8'h00, 1'b0, 1'b1, 1'b1, DIGEST_EMPTY}
    };

    typedef struct packed {
        t_word      word;
        logic [2:0] index;
        logic       last;
    } t_digest_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] data_byte
    logic [0:0]  s_axis_tuser;   // [0] has_data
    logic        s_axis_tlast;   // end_of_message
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // [31:0] digest_word
    logic [2:0]  m_axis_tuser;   // [2:0] word_index
    logic        m_axis_tlast;   // last_word

    // running hash state of the predictor
    logic [31:0] chain_h [8];
    logic [7:0]  blk_bytes [64];
    logic [5:0]  blk_count;
    logic [60:0] msg_len;
    logic [31:0] digest_out [8];

    t_digest_word digest_q [$];
    t_digest_word exp_word;

    int  mismatches  = 0;
    int  words_seen  = 0;
    int  msgs_hashed = 0;
    int  byte_reqs   = 0;
    int  noop_reqs   = 0;
    int  rand_reqs   = 0;
    bit  idle_on     = 1'b1;
    bit  stall_armed = 1'b0;

    sha256_stream_hasher_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
        logic [63:0] dbl;
        dbl = {x, x} >> n;
        return dbl[31:0];
    endfunction

    function automatic void restart_hash();
        chain_h   = IV_H;
        blk_count = '0;
        msg_len   = '0;
        foreach (blk_bytes[i]) blk_bytes[i] = 8'h00;
    endfunction

    function automatic void fold_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2, s0, s1;
        for (int i = 0; i < 16; i++)
            w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
        for (int i = 16; i < 64; i++) begin
            s0   = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
            s1   = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
        end
        v = chain_h;
        for (int i = 0; i < 64; i++) begin
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w[i];
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            chain_h[i] = chain_h[i] + v[i];
    endfunction

    function automatic void take_byte(input logic [7:0] b);
        blk_bytes[blk_count] = b;
        blk_count = blk_count + 6'd1;
        if (blk_count == 6'd0)
            fold_block();
    endfunction

    // advance the hash by one request; return 1 when a digest is ready
    function automatic bit hash_request(input logic [7:0] b, input bit hd, input bit eom);
        logic [63:0] bit_len;
        if (hd) begin
            take_byte(b);
            msg_len = msg_len + 61'd1;
        end
        if (!eom)
            return 1'b0;
        bit_len = {msg_len, 3'b000};
        take_byte(8'h80);
        while (blk_count != 6'd56)
            take_byte(8'h00);
        for (int i = 7; i >= 0; i--)
            take_byte(bit_len[8*i +: 8]);
        digest_out = chain_h;
        restart_hash();
        return 1'b1;
    endfunction

    task automatic offer_request(input logic [7:0] b, input bit hd, input bit eom,
                                 input bit use_known, input logic [255:0] known);
        t_digest_word dw;
        while (idle_on && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= hd;
        s_axis_tlast  <= eom;
        do @(posedge i_clk); while (!s_axis_tready);
        if (!hd && !eom)
            noop_reqs++;
        else if (hd)
            byte_reqs++;
        if (hash_request(b, hd, eom)) begin
            msgs_hashed++;
            for (int i = 0; i < 8; i++) begin
                dw.word  = use_known ? known[255 - 32*i -: 32] : digest_out[i];
                dw.index = i[2:0];
                dw.last  = (i == 7);
                digest_q.push_back(dw);
            end
        end
    endtask

    task automatic send_message(input int len);
        bit end_with_byte;
        end_with_byte = (len > 0) && ($urandom_range(1) == 1);
        for (int k = 0; k < len; k++) begin
            // sprinkle requests that carry neither flag
            if ($urandom_range(99) < 6)
                offer_request(8'($urandom_range(255)), 1'b0, 1'b0, 1'b0, '0);
            offer_request(8'($urandom_range(255)), 1'b1, end_with_byte && (k == len - 1),
                          1'b0, '0);
            rand_reqs++;
        end
        if (!end_with_byte) begin
            offer_request(8'($urandom_range(255)), 1'b0, 1'b1, 1'b0, '0);
            rand_reqs++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            words_seen++;
            if (digest_q.size() == 0) begin
                mismatches++;
                $display("%0t: digest word %h index %0d with nothing expected",
                         $time, m_axis_tdata, m_axis_tuser);
            end else begin
                exp_word = digest_q.pop_front();
                if (m_axis_tdata !== exp_word.word) begin
                    mismatches++;
                    $display("%0t: digest_word expected %h actual %h",
                             $time, exp_word.word, m_axis_tdata);
                end
                if (m_axis_tuser !== exp_word.index) begin
                    mismatches++;
                    $display("%0t: word_index expected %0d actual %0d",
                             $time, exp_word.index, m_axis_tuser);
                end
                if (m_axis_tlast !== exp_word.last) begin
                    mismatches++;
                    $display("%0t: last_word expected %0b actual %0b",
                             $time, exp_word.last, m_axis_tlast);
                end
            end
        end
    end

    // receiver: random backpressure, plus one long hold-off while input keeps coming
    initial begin
        int hold_cnt;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_armed && m_axis_tvalid) begin
                stall_armed = 1'b0;
                m_axis_tready <= 1'b0;
                for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++)
                    @(posedge i_clk);
            end else begin
                m_axis_tready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
            end
        end
    end

    initial begin
        #4_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        int sel;
        int len;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'h00;
        s_axis_tuser  <= 1'b0;
        s_axis_tlast  <= 1'b0;
        restart_hash();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIR_ROWS; r++)
            offer_request(DIR_TABLE[r].data_byte, DIR_TABLE[r].has_data,
                          DIR_TABLE[r].end_of_msg, DIR_TABLE[r].use_known,
                          DIR_TABLE[r].known);

        stall_armed = 1'b1;
        while (rand_reqs < RANDOM_REQS) begin
            // drop idling on both sides for a stretch in the middle
            idle_on = !(rand_reqs >= 110 && rand_reqs < 200);
            sel = $urandom_range(99);
            if (sel < 65)
                len = $urandom_range(12);
            else if (sel < 85)
                len = EDGE_LENS[$urandom_range(9)];
            else
                len = $urandom_range(130, 13);
            send_message(len);
        end
        idle_on = 1'b1;
        s_axis_tvalid <= 1'b0;

        while (digest_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Hashed %0d messages from %0d byte requests and %0d ignored requests",
                 msgs_hashed, byte_reqs, noop_reqs);
        $display("Checked %0d digest words, %0d mismatches", words_seen, mismatches);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
